### hdl/orb_pkg.sv
// package for the overwriting ring buffer with running sum
// holds sizes, operation codes and the sequencer state type; no dependencies
`timescale 1ns / 1ps

package orb_pkg;

	localparam int DEPTH     = 256;
	localparam int PTR_BITS  = $clog2(DEPTH);
	localparam int WORD_BITS = 32;
	localparam int FILL_BITS = 9;
	localparam int SUM_BITS  = 40;
	localparam int KIND_BITS = 2;
	localparam int INDEX_BITS = 8;

	localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(DEPTH);

	typedef enum logic [KIND_BITS-1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_GET  = 2'd2,
		KIND_BAD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

### hdl/orb_ifs.sv
// valid/ready channel interfaces for the ring buffer request and result streams
// depends on orb_pkg for field widths
`timescale 1ns / 1ps

interface orb_in_if
	import orb_pkg::*;
;
	logic                         valid;
	logic                         ready;
	logic [KIND_BITS-1:0]         kind;
	logic signed [WORD_BITS-1:0]  value;
	logic [INDEX_BITS-1:0]        index;

	modport source (output valid, output kind, output value, output index, input ready);
	modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface orb_out_if
	import orb_pkg::*;
;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic signed [WORD_BITS-1:0]  word;
	logic [FILL_BITS-1:0]         fill;
	logic signed [SUM_BITS-1:0]   running_sum;

	modport source (output valid, output status, output word, output fill,
		output running_sum, input ready);
	modport sink   (input valid, input status, input word, input fill,
		input running_sum, output ready);
endinterface

### hdl/orb_ram.sv
// generic single-clock ram, one write and one read port, registered read data
// no dependencies
`timescale 1ns / 1ps

module orb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/overwrite_ring_buffer_with_sum.sv
// top level: overwriting ring buffer of signed words with a running sum
// depends on orb_pkg, orb_in_if / orb_out_if and orb_ram
//
//   channel  dir  transfer carries
//   in_ch    in   kind, value, index
//   out_ch   out  status, word, fill, running_sum
//
// each request runs through idle and execute: the transfer issues the ram read,
// then the execute state modifies and writes back through the single ram port pair
// a result waits in the output register while the next request is taken;
// the sequencer holds in its execute state only while that register is full and not taken
// reset clears pointers, fill and sum at once; the store needs no clearing
// pass since only written entries are ever used in a result or the sum
`timescale 1ns / 1ps

module overwrite_ring_buffer_with_sum
	import orb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	orb_in_if.sink    in_ch,
	orb_out_if.source out_ch
);

	state_t                      state_q;
	logic [PTR_BITS-1:0]         head_q;
	logic [PTR_BITS-1:0]         tail_q;
	logic [FILL_BITS-1:0]        held_q;
	logic signed [SUM_BITS-1:0]  accum_q;

	kind_t                       kind_q;
	logic signed [WORD_BITS-1:0] value_q;
	logic [INDEX_BITS-1:0]       index_q;

	logic                        out_valid_q;
	logic                        out_status_q;
	logic signed [WORD_BITS-1:0] out_word_q;
	logic [FILL_BITS-1:0]        out_fill_q;
	logic signed [SUM_BITS-1:0]  out_sum_q;

	logic                        accept;
	logic                        exec_go;
	logic [PTR_BITS-1:0]         raddr;
	logic [WORD_BITS-1:0]        rdata;
	logic signed [SUM_BITS-1:0]  rd_ext;
	logic signed [SUM_BITS-1:0]  val_ext;
	logic                        full;
	logic                        empty;
	logic [PTR_BITS-1:0]         tail_inc;
	logic [PTR_BITS-1:0]         head_inc;

	logic                        nxt_status;
	logic signed [WORD_BITS-1:0] nxt_word;
	logic [FILL_BITS-1:0]        nxt_held;
	logic signed [SUM_BITS-1:0]  nxt_accum;
	logic [PTR_BITS-1:0]         nxt_head;
	logic [PTR_BITS-1:0]         nxt_tail;
	logic                        wr_en;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign exec_go     = (state_q == ST_EXEC) && (!out_valid_q || out_ch.ready);

	// a read by offset wraps round the ring; everything else looks at the oldest
	assign raddr = (kind_t'(in_ch.kind) == KIND_GET) ?
		head_q + PTR_BITS'(in_ch.index) : head_q;

	orb_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tail_q),
		.wdata (value_q),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_ext   = {{(SUM_BITS-WORD_BITS){rdata[WORD_BITS-1]}}, rdata};
	assign val_ext  = {{(SUM_BITS-WORD_BITS){value_q[WORD_BITS-1]}}, value_q};
	assign full     = (held_q == FULL_FILL);
	assign empty    = (held_q == '0);
	assign tail_inc = tail_q + PTR_BITS'(1);
	assign head_inc = head_q + PTR_BITS'(1);

	always_comb begin
		nxt_status = 1'b0;
		nxt_word   = '0;
		nxt_held   = held_q;
		nxt_accum  = accum_q;
		nxt_head   = head_q;
		nxt_tail   = tail_q;
		wr_en      = 1'b0;
		unique case (kind_q)
			KIND_PUSH: begin
				wr_en     = exec_go;
				nxt_tail  = tail_inc;
				// when full the oldest word is overwritten and leaves the sum
				nxt_accum = accum_q + val_ext - (full ? rd_ext : '0);
				if (full) begin
					nxt_head = tail_inc;
				end else begin
					nxt_held = held_q + FILL_BITS'(1);
				end
			end
			KIND_POP: begin
				if (empty) begin
					nxt_status = 1'b1;
				end else begin
					nxt_word  = rdata;
					nxt_accum = accum_q - rd_ext;
					nxt_head  = head_inc;
					nxt_held  = held_q - FILL_BITS'(1);
				end
			end
			KIND_GET: begin
				if ({1'b0, index_q} >= held_q) begin
					nxt_status = 1'b1;
				end else begin
					nxt_word = rdata;
				end
			end
			default: begin
				nxt_status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				head_q  <= nxt_head;
				tail_q  <= nxt_tail;
				held_q  <= nxt_held;
				accum_q <= nxt_accum;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind_t'(in_ch.kind);
			value_q <= in_ch.value;
			index_q <= in_ch.index;
		end
		if (exec_go) begin
			out_status_q <= nxt_status;
			out_word_q   <= nxt_word;
			out_fill_q   <= nxt_held;
			out_sum_q    <= nxt_accum;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.word        = out_word_q;
	assign out_ch.fill        = out_fill_q;
	assign out_ch.running_sum = out_sum_q;

`ifndef SYNTH
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_FILL)
		else $error("fill count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q - head_q) == held_q[PTR_BITS-1:0])
		else $error("head and tail disagree with fill count");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("transfer did not start the execute cycle");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && nxt_status) |=> ($stable(held_q) && $stable(accum_q)
			&& $stable(head_q) && $stable(tail_q)))
		else $error("error result changed the buffer");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !exec_go)
		else $error("result register overwritten before transfer");
`endif

endmodule
